/* design/crv_pkg.sv */
// Types and constants shared by the running variance table modules.
package crv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OP_W      = 1;
  localparam int CELL_W    = 12;
  localparam int SAMPLE_W  = 7;
  localparam int COUNT_W   = 16;
  localparam int MEAN_W    = SAMPLE_W + FRAC_BITS;
  localparam int VAR_W     = 12 + FRAC_BITS;
  localparam int PROD_W    = 2 * MEAN_W;
  localparam int NV_W      = COUNT_W + VAR_W;
  localparam int DIV_W     = 46;
  localparam int DIVSR_W   = COUNT_W;
  localparam int STEP_W    = 5;
  localparam int CELL_BITS = COUNT_W + MEAN_W + VAR_W;

  localparam logic [OP_W-1:0]    OP_ADD    = 1'b0;
  localparam logic [OP_W-1:0]    OP_CLEAR  = 1'b1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [VAR_W-1:0]   VAR_MAX   = '1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CELL_W-1:0]   cell_req;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean_q16;
    logic [VAR_W-1:0]   variance_q16;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
    logic [VAR_W-1:0]   variance;
  } cell_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DIVSR_W-1:0] divisor;
    logic [STEP_W-1:0]  pairs;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* design/crv_ram.sv */
// Generic single-port synchronous RAM with a registered read.
module crv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* design/crv_div.sv */
// Iterative restoring divider that retires two quotient bits per cycle.
module crv_div (
  input  logic               clk,
  input  logic               rst_n,
  input  crv_pkg::div_req_t  req,
  output crv_pkg::div_rsp_t  rsp
);
  import crv_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   cnt_r;
  logic [DIVSR_W-1:0]  rem_r;
  logic [DIVSR_W-1:0]  dvs_r;
  logic [DIV_W-1:0]    q_r;
  logic [DIVSR_W-1:0]  rem_mid, rem_nxt;
  logic [DIV_W-1:0]    q_mid, q_nxt;

  function automatic logic [DIVSR_W+DIV_W-1:0] div_step(
    input logic [DIVSR_W-1:0] rem,
    input logic [DIV_W-1:0]   q,
    input logic [DIVSR_W-1:0] d
  );
    logic [DIVSR_W:0] r;
    logic             ge;
    r  = {rem, q[DIV_W-1]};
    ge = (r >= {1'b0, d});
    if (ge) begin
      r = r - {1'b0, d};
    end
    return {r[DIVSR_W-1:0], q[DIV_W-2:0], ge};
  endfunction

  always_comb begin
    {rem_mid, q_mid} = div_step(rem_r, q_r, dvs_r);
    {rem_nxt, q_nxt} = div_step(rem_mid, q_mid, dvs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.pairs;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      q_r   <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

/* design/cell_running_variance_table.sv */
// Top level of the per-cell running mean and variance table.
// An add reads the cell, divides for the new mean, multiplies, and divides again for the
// variance; an add to a full cell stops after the read, and a clear or an index beyond
// the table goes straight to the output. One transaction at a time; an add uses the
// shared divider for both the mean step and the variance step.
// Reset sweeps the table to zero, one entry per cycle, with input stalled.
module cell_running_variance_table #(
  parameter int NUM_CELLS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  crv_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output crv_pkg::out_item_t out_data
);
  import crv_pkg::*;

  localparam int AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_DIV1 = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]          state_r;
  logic [AW-1:0]       clr_addr_r;
  logic [AW-1:0]       addr_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [COUNT_W-1:0]  n_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [VAR_W-1:0]    var_r;
  logic                up_r;
  logic [MEAN_W-1:0]   d1_r;
  logic [MEAN_W-1:0]   mean_new_r;
  logic [PROD_W-1:0]   prod_r;
  logic [NV_W-1:0]     nv_r;
  out_item_t           res_r;
  logic                wr_r;
  out_item_t           out_r;
  logic                out_valid_r;

  logic                ram_en, ram_we;
  logic [AW-1:0]       ram_addr;
  logic [CELL_BITS-1:0] ram_wdata, ram_rdata;
  cell_t               rd_cell;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                accept, out_free, in_range;
  logic [MEAN_W-1:0]   s_q, d1_c, q1, d2_c;
  logic                up_c;
  logic [DIV_W-1:0]    acc_c;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_range = (32'(in_data.cell_req) < NUM_CELLS);
  assign rd_cell  = cell_t'(ram_rdata);
  assign s_q      = {sample_r, {FRAC_BITS{1'b0}}};
  assign up_c     = (s_q >= rd_cell.mean);
  assign d1_c     = up_c ? (s_q - rd_cell.mean) : (rd_cell.mean - s_q);
  assign q1       = div_rsp.quotient[MEAN_W-1:0];
  assign d2_c     = (s_q >= mean_new_r) ? (s_q - mean_new_r) : (mean_new_r - s_q);
  assign acc_c    = DIV_W'(nv_r) + DIV_W'(prod_r >> FRAC_BITS);

  always_comb begin
    div_req = '0;
    if (state_r == S_CHK && rd_cell.count != COUNT_MAX) begin
      div_req.start    = 1'b1;
      div_req.dividend = {1'b0, d1_c, {(DIV_W-MEAN_W-1){1'b0}}};
      div_req.divisor  = rd_cell.count + 1'b1;
      div_req.pairs    = STEP_W'((MEAN_W + 1) / 2);
    end else if (state_r == S_ACC) begin
      div_req.start    = 1'b1;
      div_req.dividend = acc_c;
      div_req.divisor  = n_r;
      div_req.pairs    = STEP_W'(DIV_W / 2);
    end
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_r;
    ram_wdata = '0;
    case (state_r)
      S_CLR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_addr_r;
      end
      S_RD: begin
        ram_en = 1'b1;
      end
      S_DONE: begin
        if (out_free && wr_r) begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = {res_r.count, res_r.mean_q16, res_r.variance_q16};
        end
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(NUM_CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (!in_range || in_data.op == OP_CLEAR) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          state_r <= (rd_cell.count == COUNT_MAX) ? S_DONE : S_DIV1;
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: state_r <= S_DIV2;
        S_DIV2: begin
          if (div_rsp.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          addr_r   <= AW'(in_data.cell_req);
          sample_r <= in_data.sample;
          res_r    <= '0;
          wr_r     <= in_range && (in_data.op == OP_CLEAR);
        end
      end
      S_CHK: begin
        n_r    <= rd_cell.count + 1'b1;
        mean_r <= rd_cell.mean;
        var_r  <= rd_cell.variance;
        up_r   <= up_c;
        d1_r   <= d1_c;
        res_r  <= {rd_cell.count, rd_cell.mean, rd_cell.variance, 1'b1};
        wr_r   <= 1'b0;
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          mean_new_r <= up_r ? (mean_r + q1) : (mean_r - q1);
        end
      end
      S_MUL: begin
        prod_r <= PROD_W'(d1_r) * PROD_W'(d2_c);
        nv_r   <= NV_W'(n_r - 1'b1) * NV_W'(var_r);
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          res_r.count     <= n_r;
          res_r.mean_q16  <= mean_new_r;
          res_r.saturated <= 1'b0;
          if (div_rsp.quotient[DIV_W-1:VAR_W] != '0) begin
            res_r.variance_q16 <= VAR_MAX;
          end else begin
            res_r.variance_q16 <= div_rsp.quotient[VAR_W-1:0];
          end
          wr_r <= 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_r <= res_r;
        end
      end
      default: begin
        wr_r <= wr_r;
      end
    endcase
  end

  crv_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (NUM_CELLS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  crv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
